// ===== sv/flow_match_tag_extract_assert.svh =====
// Assertion macros for the flow filter.
`ifndef FLOW_MATCH_TAG_EXTRACT_ASSERT_SVH
`define FLOW_MATCH_TAG_EXTRACT_ASSERT_SVH

// Same-cycle implication.
`define FMTE_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FMTE_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/fmte_pkg.sv =====
package fmte_pkg;

    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [16:0] L2_HDR_BYTES   = 17'd14;
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [15:0] POS_MAX        = 16'hFFFF;
    localparam logic [15:0] POS_MIN_MATCH  = 16'd37;
    localparam logic [2:0]  TAG_BYTES      = 3'd4;

    localparam logic KIND_TCP = 1'b0;
    localparam logic KIND_UDP = 1'b1;

    localparam logic [1:0] CFG_CLIENT = 2'd0;
    localparam logic [1:0] CFG_SERVER = 2'd1;
    localparam logic [1:0] CFG_PORT   = 2'd2;

    typedef struct packed {
        logic [31:0] client;
        logic [31:0] server;
        logic [15:0] port;
    } fmte_cfg_t;

    typedef struct packed {
        logic        matched;
        logic        kind;
        logic [31:0] tag;
    } fmte_result_t;

endpackage

// ===== sv/fmte_parser.sv =====
`include "flow_match_tag_extract_assert.svh"

module fmte_parser
    import fmte_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  fmte_cfg_t    cfg,
    input  logic         byte_valid,
    input  logic [7:0]   byte_data,
    input  logic         byte_last,
    output fmte_result_t result
);

    logic [15:0] pos_reg, pos_next;
    logic [15:0] ether_type_reg, ether_type_next;
    logic [3:0]  ihl_reg, ihl_next;
    logic [15:0] total_len_reg, total_len_next;
    logic [7:0]  proto_reg, proto_next;
    logic [31:0] src_addr_reg, src_addr_next;
    logic [31:0] dst_addr_reg, dst_addr_next;
    logic [15:0] dport_reg, dport_next;
    logic [3:0]  doff_reg, doff_next;
    logic [31:0] tag_reg, tag_next;
    logic [2:0]  tag_count_reg, tag_count_next;

    logic [16:0] tag_end;
    logic [16:0] pos_plus4;
    logic        known;
    logic        take;
    logic        ok;

    always_comb begin
        ether_type_next = ether_type_reg;
        ihl_next        = ihl_reg;
        total_len_next  = total_len_reg;
        proto_next      = proto_reg;
        src_addr_next   = src_addr_reg;
        dst_addr_next   = dst_addr_reg;
        dport_next      = dport_reg;
        doff_next       = doff_reg;

        if (pos_reg inside {16'd12, 16'd13}) begin
            ether_type_next = {ether_type_reg[7:0], byte_data};
        end else if (pos_reg == 16'd14) begin
            ihl_next = byte_data[3:0];
        end else if (pos_reg inside {16'd16, 16'd17}) begin
            total_len_next = {total_len_reg[7:0], byte_data};
        end else if (pos_reg == 16'd23) begin
            proto_next = byte_data;
        end else if (pos_reg inside {[16'd26:16'd29]}) begin
            src_addr_next = {src_addr_reg[23:0], byte_data};
        end else if (pos_reg inside {[16'd30:16'd33]}) begin
            dst_addr_next = {dst_addr_reg[23:0], byte_data};
        end else if (pos_reg inside {16'd36, 16'd37}) begin
            dport_next = {dport_reg[7:0], byte_data};
        end else if (pos_reg == 16'd46) begin
            doff_next = byte_data[7:4];
        end

        // tag window ends at the payload offset (TCP) or the IP datagram end (UDP)
        tag_end = '0;
        known   = 1'b0;
        if (proto_next == PROTO_TCP && pos_reg >= 16'd47) begin
            tag_end = L2_HDR_BYTES + {11'd0, ihl_next, 2'b00} + {11'd0, doff_next, 2'b00};
            known   = 1'b1;
        end else if (proto_next == PROTO_UDP && pos_reg >= 16'd24) begin
            tag_end = L2_HDR_BYTES + {1'b0, total_len_next};
            known   = 1'b1;
        end

        pos_plus4 = {1'b0, pos_reg} + 17'd4;
        take = known && (pos_reg != POS_MAX) && (pos_plus4 >= tag_end)
            && ({1'b0, pos_reg} < tag_end) && (tag_count_reg < TAG_BYTES);

        tag_next       = tag_reg;
        tag_count_next = tag_count_reg;
        if (take) begin
            tag_next       = {tag_reg[23:0], byte_data};
            tag_count_next = tag_count_reg + 3'd1;
        end

        ok = (ether_type_next == ETHERTYPE_IPV4)
            && (src_addr_next == cfg.client)
            && (dst_addr_next == cfg.server)
            && (dport_next == cfg.port)
            && (proto_next == PROTO_TCP || proto_next == PROTO_UDP)
            && (tag_count_next == TAG_BYTES)
            && (pos_reg >= POS_MIN_MATCH);

        result.matched = ok;
        result.kind    = (ok && proto_next == PROTO_UDP) ? KIND_UDP : KIND_TCP;
        result.tag     = ok ? tag_next : '0;

        pos_next = (pos_reg != POS_MAX) ? pos_reg + 16'd1 : pos_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (byte_valid && byte_last)) begin
            pos_reg        <= '0;
            ether_type_reg <= '0;
            ihl_reg        <= '0;
            total_len_reg  <= '0;
            proto_reg      <= '0;
            src_addr_reg   <= '0;
            dst_addr_reg   <= '0;
            dport_reg      <= '0;
            doff_reg       <= '0;
            tag_reg        <= '0;
            tag_count_reg  <= '0;
        end else if (byte_valid) begin
            pos_reg        <= pos_next;
            ether_type_reg <= ether_type_next;
            ihl_reg        <= ihl_next;
            total_len_reg  <= total_len_next;
            proto_reg      <= proto_next;
            src_addr_reg   <= src_addr_next;
            dst_addr_reg   <= dst_addr_next;
            dport_reg      <= dport_next;
            doff_reg       <= doff_next;
            tag_reg        <= tag_next;
            tag_count_reg  <= tag_count_next;
        end
    end

    `FMTE_ASSERT_NXT(a_pos_clear, aclk, aresetn, byte_valid && byte_last,
        (pos_reg == '0) && (tag_count_reg == '0), "frame state not cleared after last byte")
    `FMTE_ASSERT_NXT(a_pos_step, aclk, aresetn,
        byte_valid && !byte_last && (pos_reg != POS_MAX),
        pos_reg == $past(pos_reg) + 16'd1, "byte position did not advance")
    `FMTE_ASSERT_IMP(a_tag_count, aclk, aresetn, 1'b1, tag_count_reg <= TAG_BYTES,
        "tag byte count beyond four")

endmodule

// ===== sv/fmte_out_stage.sv =====
`include "flow_match_tag_extract_assert.svh"

module fmte_out_stage
    import fmte_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         load,
    input  fmte_result_t result,
    output logic         free,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,
    output logic [1:0]   m_tuser
);

    logic         valid_reg, valid_next;
    fmte_result_t result_reg;

    assign free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = result_reg.tag;
    assign m_tuser  = {result_reg.kind, result_reg.matched};

    `FMTE_ASSERT_IMP(a_nomatch_zero, aclk, aresetn, valid_reg && !result_reg.matched, (result_reg.kind == KIND_TCP) && (result_reg.tag == '0), "unmatched result carries kind or tag")
    `FMTE_ASSERT_IMP(a_load_free, aclk, aresetn, load, free, "result loaded over a pending transfer")

endmodule

// ===== sv/flow_match_tag_extract.sv =====
// m_tvalid rises once the last byte has left the input register for the result register.
// Throughput: one byte per cycle unless a last byte waits; one result per frame.
// A last byte waits in the input register while the previous result is not yet taken.
// A byte goes from the input register through field capture into the result register.
// Reset (aresetn low, synchronous): frame state, addresses and port cleared to zero,
// no result pending.
module flow_match_tag_extract
    import fmte_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] frame_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] packet_tag
    output logic [1:0]  m_tuser,   // [0] matched, [1] transport_kind
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    fmte_cfg_t    cfg_reg;
    fmte_result_t result;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       out_free;
    logic       consume;
    logic       s_accept;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_CLIENT: cfg_reg.client <= cfg_data;
                CFG_SERVER: cfg_reg.server <= cfg_data;
                CFG_PORT:   cfg_reg.port   <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // last byte waits for a free result register
    assign consume  = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || consume;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (consume) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    fmte_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .byte_valid (consume),
        .byte_data  (in_byte_reg),
        .byte_last  (in_last_reg),
        .result     (result)
    );

    fmte_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (consume && in_last_reg),
        .result   (result),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
